// ----- rtl/status_led_blink_controller_macros.svh -----
// Assertion macros shared by the status LED controller RTL.
// Each macro takes a label, the clock, the active-low reset and the
// two sides of the implication.
`ifndef STATUS_LED_BLINK_CONTROLLER_MACROS_SVH
`define STATUS_LED_BLINK_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SLBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("status LED controller check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("status LED controller check failed");

`else

`define SLBC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SLBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/slbc_pkg.sv -----
package slbc_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int CMD_W    = 2;
	localparam int COUNT_W  = 8;
	localparam int NOW_W    = 32;
	localparam int COLOR_W  = 24;
	localparam int MODE_W   = 2;
	localparam int IVAL_W   = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Commands carried in the input beat.
	localparam logic [CMD_W-1:0] CMD_ERROR    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_IDENTIFY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TIME     = 2'd3;

	// LED modes as reported on the output.
	localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ERROR    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDENTIFY = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_INTERVAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDENTIFY_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_COLOR       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDENTIFY_COLOR    = 2'd3;

	// Configuration reset values.
	localparam logic [IVAL_W-1:0]  ERROR_INTERVAL_RST    = 16'd500;
	localparam logic [IVAL_W-1:0]  IDENTIFY_INTERVAL_RST = 16'd300;
	localparam logic [COLOR_W-1:0] ERROR_COLOR_RST       = 24'hFF0000;
	localparam logic [COLOR_W-1:0] IDENTIFY_COLOR_RST    = 24'hFFFF00;
	localparam logic [COLOR_W-1:0] COLOR_DARK            = 24'h000000;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COUNT_W-1:0] blink_count;
		logic [NOW_W-1:0]   now_ms;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               lit;
		logic [MODE_W-1:0]  mode;
	} out_item_t;

	typedef struct packed {
		logic [IVAL_W-1:0]  error_interval_ms;
		logic [IVAL_W-1:0]  identify_interval_ms;
		logic [COLOR_W-1:0] error_color;
		logic [COLOR_W-1:0] identify_color;
	} cfg_t;

endpackage

// ----- rtl/slbc_chan_if.sv -----
interface slbc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/slbc_cfg.sv -----
module slbc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slbc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output slbc_pkg::cfg_t                      cfg
);
	import slbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_interval_ms    <= ERROR_INTERVAL_RST;
			cfg_q.identify_interval_ms <= IDENTIFY_INTERVAL_RST;
			cfg_q.error_color          <= ERROR_COLOR_RST;
			cfg_q.identify_color       <= IDENTIFY_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ERROR_INTERVAL:    cfg_q.error_interval_ms    <= cfg_wdata[IVAL_W-1:0];
				CFG_IDENTIFY_INTERVAL: cfg_q.identify_interval_ms <= cfg_wdata[IVAL_W-1:0];
				CFG_ERROR_COLOR:       cfg_q.error_color          <= cfg_wdata[COLOR_W-1:0];
				CFG_IDENTIFY_COLOR:    cfg_q.identify_color       <= cfg_wdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/slbc_engine.sv -----
`include "status_led_blink_controller_macros.svh"

module slbc_engine #(
	parameter int TIME_BITS = slbc_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  slbc_pkg::in_item_t    item,
	input  slbc_pkg::cfg_t        cfg,
	output slbc_pkg::out_item_t   result
);
	import slbc_pkg::*;

	logic [MODE_W-1:0]    mode_q, mode_n;
	logic                 saved_err_q, saved_err_n;
	logic [TIME_BITS-1:0] last_q, last_n;
	logic                 phase_q, phase_n;
	logic [COUNT_W-1:0]   wanted_q, wanted_n;
	logic [COUNT_W-1:0]   done_q, done_n;

	logic [TIME_BITS-1:0] now_w;
	logic [TIME_BITS-1:0] elapsed;
	logic [COUNT_W-1:0]   done_inc;
	logic                 err_due;
	logic                 id_due;

	// The timestamp wraps at the timer width; elapsed time wraps with it.
	assign now_w    = TIME_BITS'(item.now_ms);
	assign elapsed  = now_w - last_q;
	assign err_due  = elapsed >= TIME_BITS'(cfg.error_interval_ms);
	assign id_due   = elapsed >= TIME_BITS'(cfg.identify_interval_ms);
	assign done_inc = done_q + COUNT_W'(1);

	always_comb begin
		mode_n      = mode_q;
		saved_err_n = saved_err_q;
		last_n      = last_q;
		phase_n     = phase_q;
		wanted_n    = wanted_q;
		done_n      = done_q;
		unique case (item.command)
			CMD_ERROR: begin
				if (mode_q == MODE_IDENTIFY) begin
					saved_err_n = 1'b1;
				end else begin
					mode_n  = MODE_ERROR;
					last_n  = '0;
					phase_n = 1'b1;
				end
			end
			CMD_CLEAR: begin
				if (mode_q == MODE_IDENTIFY) begin
					saved_err_n = 1'b0;
				end else begin
					mode_n  = MODE_OFF;
					phase_n = 1'b0;
				end
			end
			CMD_IDENTIFY: begin
				if (item.blink_count != '0) begin
					if (mode_q != MODE_IDENTIFY) begin
						saved_err_n = (mode_q == MODE_ERROR);
					end
					mode_n   = MODE_IDENTIFY;
					wanted_n = item.blink_count;
					done_n   = '0;
					last_n   = '0;
					phase_n  = 1'b1;
				end
			end
			CMD_TIME: begin
				if (mode_q != MODE_OFF) begin
					if (last_q == '0) begin
						// A zero timestamp means the timer is not running yet.
						last_n = now_w;
					end else if (mode_q == MODE_ERROR) begin
						if (err_due) begin
							phase_n = ~phase_q;
							last_n  = now_w;
						end
					end else if (id_due) begin
						last_n = now_w;
						if (phase_q) begin
							phase_n = 1'b0;
							done_n  = done_inc;
							if (done_inc >= wanted_q) begin
								// Last blink finished: go back to the saved mode.
								wanted_n = '0;
								done_n   = '0;
								if (saved_err_q) begin
									mode_n  = MODE_ERROR;
									last_n  = '0;
									phase_n = 1'b1;
								end else begin
									mode_n  = MODE_OFF;
									phase_n = 1'b0;
								end
							end
						end else begin
							phase_n = 1'b1;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			saved_err_q <= 1'b0;
			last_q      <= '0;
			phase_q     <= 1'b0;
			wanted_q    <= '0;
			done_q      <= '0;
		end else if (step) begin
			mode_q      <= mode_n;
			saved_err_q <= saved_err_n;
			last_q      <= last_n;
			phase_q     <= phase_n;
			wanted_q    <= wanted_n;
			done_q      <= done_n;
		end
	end

	always_comb begin
		result.lit  = phase_n;
		result.mode = mode_n;
		if (phase_n && mode_n == MODE_ERROR) begin
			result.color = cfg.error_color;
		end else if (phase_n && mode_n == MODE_IDENTIFY) begin
			result.color = cfg.identify_color;
		end else begin
			result.color = COLOR_DARK;
		end
	end

	`SLBC_ASSERT_SAME(a_off_is_dark, clk, arst_n, mode_q == MODE_OFF, !phase_q)
	`SLBC_ASSERT_SAME(a_identify_has_count, clk, arst_n, mode_q == MODE_IDENTIFY, wanted_q != '0)
	`SLBC_ASSERT_SAME(a_identify_not_done, clk, arst_n, mode_q == MODE_IDENTIFY, done_q < wanted_q)

endmodule

// ----- rtl/status_led_blink_controller.sv -----
// Status LED blink controller.
//
// Commands arrive as beats on in_ch (valid/ready): enter error, clear, start
// identify with a blink count, or a time update with a millisecond stamp.
// Every accepted beat produces exactly one beat on out_ch with the LED color,
// the lit bit and the mode as they stand after that command.
// Configuration (blink intervals and colors) is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while no command is
// in flight, and the block itself does not enforce this. A beat is captured
// in the input register; when stage 1 advances, the mode logic updates the
// state and loads the output register. One beat can be accepted every cycle
// while the receiver keeps up, so back-to-back beats never wait on each other.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and in_ch.ready drops until out_ch.ready returns.
// Reset clears both registers, puts the LED in off mode with a stopped
// timer, and loads the default intervals and colors.
`include "status_led_blink_controller_macros.svh"

module status_led_blink_controller #(
	parameter int TIME_BITS = slbc_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	slbc_chan_if.sink                       in_ch,
	slbc_chan_if.source                     out_ch,
	input  logic                            cfg_we,
	input  logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import slbc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t data_s2;
	logic      valid_s2;
	logic      advance;

	// The stage-1 beat moves on whenever the output register is empty or
	// being emptied in this cycle.
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
	end

	slbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	slbc_engine #(
		.TIME_BITS (TIME_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Output register: loads a new result when stage 1 advances, and
	// otherwise drops its beat once the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = data_s2;

	`SLBC_ASSERT_NEXT(a_result_follows_step, clk, arst_n, advance, valid_s2)

endmodule
